FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define NTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check an implication on every rising edge of clk outside reset.
`define NTS_ASSERT_IMP(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) else $error(msg);

`endif

FILE: rtl/nts_pkg.sv
package nts_pkg;

	localparam int DEF_MAX_POINTS = 256;
	localparam int DEF_COORD_BITS = 12;

	localparam int NEAR_W  = 21;
	localparam int SLOT_W  = 8;
	localparam int OP_W    = 2;
	localparam int INDEX_W = 8;
	localparam int COUNT_W = 9;
	localparam int COLS_W  = 12;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam logic [COLS_W-1:0] COLS_RESET = 12'd640;

	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_POINT = 2'd1;
	localparam logic [OP_W-1:0] OP_SEG   = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

	localparam logic REG_COUNT = 1'b0;
	localparam logic REG_COLS  = 1'b1;

endpackage

FILE: rtl/nts_if.sv
interface nts_cmd_if #(
	parameter int COORD_BITS = nts_pkg::DEF_COORD_BITS
);
	import nts_pkg::*;
	logic                         valid;
	logic                         ready;
	logic [OP_W-1:0]              opcode;
	logic [SLOT_W-1:0]            slot;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;

	modport source (output valid, opcode, slot, coord_x, coord_y, input ready);
	modport sink (input valid, opcode, slot, coord_x, coord_y, output ready);
endinterface

interface nts_rsp_if;
	import nts_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     found;
	logic [INDEX_W-1:0]       nearest_index;
	logic signed [NEAR_W-1:0] near_x;
	logic signed [NEAR_W-1:0] near_y;

	modport source (output valid, found, nearest_index, near_x, near_y, input ready);
	modport sink (input valid, found, nearest_index, near_x, near_y, output ready);
endinterface

FILE: rtl/nearest_track_segment_finder.sv
// A load writes the point memory directly; a point query visits each stored point, and the result
// waits for the output handshake. A segment query visits each segment, using the restoring
// divider, and skipped segments finish sooner; throughput is one item at a time.
// One shared multiplier and one divider step do all multiplication and division under the sequencer.
// Reset (arst_n low, asynchronous) clears control, point_count to 0, screen_columns to 640;
// the track point memory is not cleared and holds garbage until loaded.
module nearest_track_segment_finder #(
	parameter int MAX_POINTS = nts_pkg::DEF_MAX_POINTS,
	parameter int COORD_BITS = nts_pkg::DEF_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	nts_cmd_if.sink                      cmd,
	nts_rsp_if.source                    rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [nts_pkg::APB_AW-1:0]   paddr,
	input  logic [nts_pkg::APB_DW-1:0]   pwdata,
	output logic [nts_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);
	import nts_pkg::*;

	`include "assert_macros.svh"

	// Widths: D holds a coordinate difference, MW the shared multiplier operand.
	localparam int C   = COORD_BITS;
	localparam int D   = C + 1;
	localparam int MW  = D + 10;
	localparam int PW  = 2 * MW;
	localparam int BW  = PW + 1;
	localparam int LW  = 2 * D;
	localparam int RW  = LW + 1;
	localparam int QW  = 17;
	localparam int TW  = 18;
	localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int DCW = $clog2(QW);

	localparam logic [QW-1:0] LIM_NEG = 17'd32768;
	localparam logic [QW-1:0] LIM_POS = 17'd98304;

	// Sequencer states.
	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_TH    = 5'd1;
	localparam logic [4:0] ST_TH2   = 5'd2;
	localparam logic [4:0] ST_P_RD  = 5'd3;
	localparam logic [4:0] ST_P_M1  = 5'd4;
	localparam logic [4:0] ST_P_M2  = 5'd5;
	localparam logic [4:0] ST_P_CMP = 5'd6;
	localparam logic [4:0] ST_S_RD0 = 5'd7;
	localparam logic [4:0] ST_S_LD0 = 5'd8;
	localparam logic [4:0] ST_S_RD  = 5'd9;
	localparam logic [4:0] ST_S_DIF = 5'd10;
	localparam logic [4:0] ST_S_M1  = 5'd11;
	localparam logic [4:0] ST_S_M2  = 5'd12;
	localparam logic [4:0] ST_S_M3  = 5'd13;
	localparam logic [4:0] ST_S_M4  = 5'd14;
	localparam logic [4:0] ST_S_M5  = 5'd15;
	localparam logic [4:0] ST_S_DIV = 5'd16;
	localparam logic [4:0] ST_S_CHK = 5'd17;
	localparam logic [4:0] ST_S_M6  = 5'd18;
	localparam logic [4:0] ST_S_M7  = 5'd19;
	localparam logic [4:0] ST_S_M8  = 5'd20;
	localparam logic [4:0] ST_S_M9  = 5'd21;
	localparam logic [4:0] ST_S_M10 = 5'd22;
	localparam logic [4:0] ST_S_CMP = 5'd23;
	localparam logic [4:0] ST_S_NX  = 5'd24;
	localparam logic [4:0] ST_DONE  = 5'd25;

	function automatic logic signed [NEAR_W-1:0] sat_near(input logic signed [MW:0] v);
		logic signed [MW:0] hi;
		logic signed [MW:0] lo;
		hi = (MW+1)'(signed'({1'b0, {(NEAR_W-1){1'b1}}}));
		lo = -hi - (MW+1)'(1);
		if (v > hi) begin
			return {1'b0, {(NEAR_W-1){1'b1}}};
		end else if (v < lo) begin
			return {1'b1, {(NEAR_W-1){1'b0}}};
		end
		return v[NEAR_W-1:0];
	endfunction

	// Configuration registers.
	logic [COUNT_W-1:0] pcount_q;
	logic [COLS_W-1:0]  cols_q;

	// Track point memory: {y, x}.
	logic [2*C-1:0] mem [MAX_POINTS];
	logic [2*C-1:0] rd_q;
	logic           rd_en;
	logic [AW-1:0]  raddr;
	logic           wr_en;

	// Sequencer and datapath registers.
	logic [4:0]             state_q;
	logic                   seg_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          n_q;
	logic signed [C-1:0]    qx_q, qy_q, px_q, py_q;
	logic signed [D-1:0]    x0_q, y0_q, x1_q, y1_q;
	logic signed [PW-1:0]   prod_q, acc_q;
	logic [LW-1:0]          len2_q;
	logic [RW-1:0]          r_q;
	logic [QW-1:0]          quo_q;
	logic                   neg_q;
	logic [DCW-1:0]         dcnt_q;
	logic signed [TW-1:0]   t_q;
	logic signed [MW-1:0]   tx_q, ty_q, lx_q, ly_q;
	logic [BW-1:0]          best_q;
	logic                   found_q;
	logic [AW-1:0]          idx_q;
	logic signed [NEAR_W-1:0] nx_q, ny_q;

	// Combinational helpers.
	logic signed [C-1:0]  rd_x, rd_y;
	logic signed [D-1:0]  dx, dy;
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod;
	logic signed [PW:0]   sum;
	logic [BW-1:0]        d2;
	logic signed [RW-1:0] dot;
	logic [RW-1:0]        abs_dot;
	logic [RW:0]          trial;
	logic                 qbit;
	logic [RW-1:0]        r_new;
	logic signed [MW-1:0] ty_new;
	logic [CW:0]          cnt_p1, cnt_p2;
	logic [CW-1:0]        n_lim;
	logic                 cfg_wr;

	assign rd_x = signed'(rd_q[C-1:0]);
	assign rd_y = signed'(rd_q[2*C-1:C]);
	assign dx   = D'(qx_q) - D'(rd_x);
	assign dy   = D'(qy_q) - D'(rd_y);

	// Shared multiplier, registered every cycle.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_TH: begin
				mul_a = MW'(signed'({1'b0, cols_q}));
				mul_b = MW'(signed'({1'b0, cols_q}));
			end
			ST_P_M1: begin
				mul_a = MW'(dx);
				mul_b = MW'(dx);
			end
			ST_P_M2: begin
				mul_a = MW'(dy);
				mul_b = MW'(dy);
			end
			ST_S_M1: begin
				mul_a = MW'(x1_q);
				mul_b = MW'(x1_q);
			end
			ST_S_M2: begin
				mul_a = MW'(y1_q);
				mul_b = MW'(y1_q);
			end
			ST_S_M3: begin
				mul_a = MW'(x0_q);
				mul_b = MW'(x1_q);
			end
			ST_S_M4: begin
				mul_a = MW'(y0_q);
				mul_b = MW'(y1_q);
			end
			ST_S_M6: begin
				mul_a = MW'(x1_q);
				mul_b = MW'(t_q);
			end
			ST_S_M7: begin
				mul_a = MW'(y1_q);
				mul_b = MW'(t_q);
			end
			ST_S_M9: begin
				mul_a = lx_q;
				mul_b = lx_q;
			end
			ST_S_M10: begin
				mul_a = ly_q;
				mul_b = ly_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod    = mul_a * mul_b;
	assign sum     = (PW+1)'(acc_q) + (PW+1)'(prod_q);
	assign d2      = BW'(unsigned'(sum));
	assign dot     = RW'(sum);
	assign abs_dot = dot[RW-1] ? RW'(-dot) : RW'(dot);

	// One restoring division step: subtract if it fits, then shift.
	assign trial  = {1'b0, r_q} - (RW+1)'(len2_q);
	assign qbit   = !trial[RW];
	assign r_new  = qbit ? trial[RW-1:0] : r_q;
	assign ty_new = MW'(prod_q >>> 8);

	assign cnt_p1 = (CW+1)'(cnt_q) + (CW+1)'(1);
	assign cnt_p2 = (CW+1)'(cnt_q) + (CW+1)'(2);
	assign n_lim  = (32'(pcount_q) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(pcount_q);

	// Memory access: write on a load, read the point the sequencer needs.
	assign wr_en = cmd.valid && cmd.ready && (cmd.opcode == OP_LOAD)
		&& (32'(cmd.slot) < MAX_POINTS);
	assign rd_en = (state_q == ST_P_RD) || (state_q == ST_S_RD0) || (state_q == ST_S_RD);

	always_comb begin
		unique case (state_q)
			ST_P_RD:  raddr = cnt_q[AW-1:0];
			ST_S_RD:  raddr = cnt_p1[AW-1:0];
			default:  raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(cmd.slot)] <= {cmd.coord_y, cmd.coord_x};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[raddr];
		end
	end

	// APB register file; writes land on the access phase.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q <= '0;
			cols_q   <= COLS_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_COUNT: pcount_q <= pwdata[COUNT_W-1:0];
				REG_COLS:  cols_q   <= pwdata[COLS_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_COUNT: prdata = APB_DW'(pcount_q);
			REG_COLS:  prdata = APB_DW'(cols_q);
			default:   prdata = '0;
		endcase
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			found_q <= 1'b0;
			cnt_q   <= '0;
			dcnt_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.valid && ((cmd.opcode == OP_POINT) || (cmd.opcode == OP_SEG))) begin
						found_q <= 1'b0;
						cnt_q   <= '0;
						state_q <= ST_TH;
					end
				end
				ST_TH: state_q <= ST_TH2;
				ST_TH2: begin
					// Skip the scan when nothing can qualify.
					if (seg_q) begin
						state_q <= (n_q < CW'(2)) ? ST_DONE : ST_S_RD0;
					end else begin
						state_q <= (n_q == '0) ? ST_DONE : ST_P_RD;
					end
				end
				ST_P_RD:  state_q <= ST_P_M1;
				ST_P_M1:  state_q <= ST_P_M2;
				ST_P_M2:  state_q <= ST_P_CMP;
				ST_P_CMP: begin
					if (d2 < best_q) begin
						found_q <= 1'b1;
					end
					cnt_q   <= cnt_p1[CW-1:0];
					state_q <= (cnt_p1 < (CW+1)'(n_q)) ? ST_P_RD : ST_DONE;
				end
				ST_S_RD0: state_q <= ST_S_LD0;
				ST_S_LD0: state_q <= ST_S_RD;
				ST_S_RD:  state_q <= ST_S_DIF;
				ST_S_DIF: state_q <= ST_S_M1;
				ST_S_M1:  state_q <= ST_S_M2;
				ST_S_M2:  state_q <= ST_S_M3;
				ST_S_M3:  state_q <= ST_S_M4;
				ST_S_M4:  state_q <= ST_S_M5;
				ST_S_M5: begin
					// Drop zero-length segments and factors of two or more.
					if ((len2_q == '0) || ({1'b0, abs_dot} >= {len2_q, 2'b00} >> 1)) begin
						state_q <= ST_S_NX;
					end else begin
						dcnt_q  <= '0;
						state_q <= ST_S_DIV;
					end
				end
				ST_S_DIV: begin
					dcnt_q <= dcnt_q + DCW'(1);
					if (dcnt_q == DCW'(QW - 1)) begin
						state_q <= ST_S_CHK;
					end
				end
				ST_S_CHK: begin
					if (quo_q > (neg_q ? LIM_NEG : LIM_POS)) begin
						state_q <= ST_S_NX;
					end else begin
						state_q <= ST_S_M6;
					end
				end
				ST_S_M6:  state_q <= ST_S_M7;
				ST_S_M7:  state_q <= ST_S_M8;
				ST_S_M8:  state_q <= ST_S_M9;
				ST_S_M9:  state_q <= ST_S_M10;
				ST_S_M10: state_q <= ST_S_CMP;
				ST_S_CMP: begin
					if (d2 < best_q) begin
						found_q <= 1'b1;
					end
					state_q <= ST_S_NX;
				end
				ST_S_NX: begin
					// Advance: the end point becomes the next start point.
					cnt_q   <= cnt_p1[CW-1:0];
					state_q <= ((CW+2)'(cnt_p2) + (CW+2)'(1) <= (CW+2)'(n_q)) ? ST_S_RD
						: ST_DONE;
				end
				ST_DONE: begin
					if (rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= prod;
		unique case (state_q)
			ST_IDLE: begin
				qx_q  <= cmd.coord_x;
				qy_q  <= cmd.coord_y;
				seg_q <= (cmd.opcode == OP_SEG);
				n_q   <= n_lim;
				idx_q <= '0;
				nx_q  <= '0;
				ny_q  <= '0;
			end
			ST_TH2: begin
				// Point: 2*cols^2.  Segment: (2*cols)^2 in Q16.
				best_q <= seg_q ? (BW'(unsigned'(prod_q)) << 18)
					: (BW'(unsigned'(prod_q)) << 1);
			end
			ST_P_M2: acc_q <= prod_q;
			ST_P_CMP: begin
				if (d2 < best_q) begin
					best_q <= d2;
					idx_q  <= cnt_q[AW-1:0];
				end
			end
			ST_S_LD0: begin
				px_q <= rd_x;
				py_q <= rd_y;
			end
			ST_S_DIF: begin
				x0_q <= D'(qx_q) - D'(px_q);
				y0_q <= D'(qy_q) - D'(py_q);
				x1_q <= D'(rd_x) - D'(px_q);
				y1_q <= D'(rd_y) - D'(py_q);
			end
			ST_S_M2: acc_q <= prod_q;
			ST_S_M3: len2_q <= LW'(unsigned'(sum));
			ST_S_M4: acc_q <= prod_q;
			ST_S_M5: begin
				r_q   <= abs_dot;
				neg_q <= dot[RW-1];
				quo_q <= '0;
			end
			ST_S_DIV: begin
				quo_q <= {quo_q[QW-2:0], qbit};
				r_q   <= {r_new[RW-2:0], 1'b0};
			end
			ST_S_CHK: t_q <= neg_q ? -TW'(quo_q) : TW'(quo_q);
			ST_S_M7: tx_q <= MW'(prod_q >>> 8);
			ST_S_M8: begin
				ty_q <= ty_new;
				lx_q <= (MW'(x0_q) <<< 8) - tx_q;
				ly_q <= (MW'(y0_q) <<< 8) - ty_new;
			end
			ST_S_M10: acc_q <= prod_q;
			ST_S_CMP: begin
				if (d2 < best_q) begin
					best_q <= d2;
					idx_q  <= cnt_q[AW-1:0];
					nx_q   <= sat_near(((MW+1)'(px_q) <<< 8) + (MW+1)'(tx_q));
					ny_q   <= sat_near(((MW+1)'(py_q) <<< 8) + (MW+1)'(ty_q));
				end
			end
			ST_S_NX: begin
				px_q <= rd_x;
				py_q <= rd_y;
			end
			default: ;
		endcase
	end

	// Handshakes: take items only while idle, hold the result until taken.
	assign cmd.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = (state_q == ST_DONE);
	assign rsp.found         = found_q;
	assign rsp.nearest_index = INDEX_W'(idx_q);
	assign rsp.near_x        = nx_q;
	assign rsp.near_y        = ny_q;

	`NTS_ASSERT_IMP(a_div_len, state_q == ST_S_DIV, r_q < {len2_q, 1'b0}, "divider remainder out of range")
	`NTS_ASSERT_IMP(a_miss_zero, rsp.valid && !rsp.found, (rsp.nearest_index == '0) && (rsp.near_x == '0) && (rsp.near_y == '0), "miss result not zero")
	`NTS_ASSERT_IMP(a_scan_bound, (state_q == ST_P_RD) || (state_q == ST_S_RD), cnt_q < n_q, "scan index past point count")
	`NTS_ASSERT_IMP(a_done_hold, (state_q == ST_DONE) && !rsp.ready, ##1 (state_q == ST_DONE), "result dropped before taken")

endmodule
